@@ rtl/sorted_insert_priority_queue_core_defines.svh @@
// Assertion macros for the sorted insert priority queue core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SIPQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define SIPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sipq_pkg.sv @@
// Shared types and constants for the sorted insert priority queue core.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package sipq_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 8;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [TAG_BITS-1:0] tag_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		key_t key;
		tag_t tag;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic publish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic reject;
		logic last;
	} sts_t;

endpackage

@@ rtl/sipq_ctrl.sv @@
// Sequencer for the sorted insert priority queue core.
// Depends on sipq_pkg for the command and status structs.
module sipq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_stall,
	input  sipq_pkg::sts_t  sts,
	output logic            in_stall,
	output logic            out_valid,
	output sipq_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_WALK = 4'b0100,
		S_PUB  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   pub_ok;

	// Result register is free when empty or being taken
	assign pub_ok = !out_valid_q || !out_stall;

	// Drive commands and next state
	always_comb begin
		state_d     = state_q;
		cmd.accept  = 1'b0;
		cmd.step    = 1'b0;
		cmd.publish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.reject ? S_PUB : S_PREP;
				end
			end
			S_PREP: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = S_PUB;
				end
			end
			S_PUB: begin
				if (pub_ok) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/sipq_dp.sv @@
// Datapath for the sorted insert priority queue core: slot memory, walk
// counter, carry register, head copy and result registers. Uses sipq_pkg.
module sipq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sipq_pkg::cmd_t      cmd,
	output sipq_pkg::sts_t      sts,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  logic                operation,
	input  sipq_pkg::key_t      entry_key,
	input  sipq_pkg::tag_t      entry_tag,
	output sipq_pkg::key_t      head_key,
	output sipq_pkg::tag_t      head_tag,
	output logic                head_valid,
	output sipq_pkg::cnt_t      entry_count,
	output sipq_pkg::status_t   status
);

	sipq_pkg::slot_t   mem [sipq_pkg::DEPTH];
	sipq_pkg::slot_t   rd_q;
	sipq_pkg::slot_t   carry_q;
	sipq_pkg::slot_t   head_q;
	sipq_pkg::slot_t   wdata;
	sipq_pkg::idx_t    idx_q;
	sipq_pkg::idx_t    rd_addr;
	sipq_pkg::cnt_t    count_q;
	sipq_pkg::cnt_t    idx_ext;
	sipq_pkg::op_t     op_q;
	sipq_pkg::key_t    key_q;
	sipq_pkg::tag_t    tag_q;
	sipq_pkg::status_t status_q;
	sipq_pkg::status_t status_d;
	logic              order_q;
	logic              placed_q;
	logic              we;
	logic              take_carry;
	logic              place;
	logic              ahead;
	logic              in_range;
	logic              more;
	sipq_pkg::key_t    res_key_q;
	sipq_pkg::tag_t    res_tag_q;
	logic              res_valid_q;
	sipq_pkg::cnt_t    res_count_q;
	sipq_pkg::status_t res_status_q;

	assign idx_ext = sipq_pkg::cnt_t'(idx_q);

	// Refuse an insert into a full queue and a remove from an empty one
	always_comb begin
		status_d = sipq_pkg::STATUS_OK;
		if (operation == sipq_pkg::OP_INSERT) begin
			if (count_q == sipq_pkg::cnt_t'(sipq_pkg::DEPTH)) begin
				status_d = sipq_pkg::STATUS_FULL;
			end
		end else if (count_q == '0) begin
			status_d = sipq_pkg::STATUS_EMPTY;
		end
	end
	assign sts.reject = (status_d != sipq_pkg::STATUS_OK);

	// Read one slot ahead of the write position (two ahead on remove)
	assign rd_addr = idx_q + sipq_pkg::idx_t'(op_q) + sipq_pkg::idx_t'(cmd.step);

	// Held entry stays ahead of the new one under the current ordering
	assign ahead    = order_q ? (rd_q.key < key_q) : (rd_q.key > key_q);
	assign in_range = idx_ext < count_q;
	assign more     = (idx_ext + sipq_pkg::cnt_t'(1)) < count_q;

	// Decide the slot write of this walk step
	always_comb begin
		we         = 1'b0;
		wdata      = carry_q;
		take_carry = 1'b0;
		place      = 1'b0;
		if (cmd.step) begin
			if (op_q == sipq_pkg::OP_INSERT) begin
				if (placed_q) begin
					we         = 1'b1;
					take_carry = 1'b1;
				end else if (!(in_range && ahead)) begin
					we         = 1'b1;
					wdata      = '{key: key_q, tag: tag_q};
					take_carry = 1'b1;
					place      = 1'b1;
				end
			end else if (more) begin
				we    = 1'b1;
				wdata = rd_q;
			end
		end
	end
	assign sts.last = (op_q == sipq_pkg::OP_INSERT) ? (idx_ext == count_q) : !more;

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Latch the transaction and walk payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= sipq_pkg::op_t'(operation);
			key_q    <= entry_key;
			tag_q    <= entry_tag;
			status_q <= status_d;
		end
		if (take_carry) begin
			carry_q <= rd_q;
		end
		if (we && idx_q == '0) begin
			head_q <= wdata;
		end
		if (cmd.publish) begin
			res_key_q    <= (count_q != '0) ? head_q.key : '0;
			res_tag_q    <= (count_q != '0) ? head_q.tag : '0;
			res_valid_q  <= (count_q != '0);
			res_count_q  <= count_q;
			res_status_q <= status_q;
		end
	end

	// Control registers: ordering, occupancy, walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= 1'b0;
			count_q  <= '0;
			idx_q    <= '0;
			placed_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				order_q <= cfg_write_data;
			end
			if (cmd.accept) begin
				idx_q    <= '0;
				placed_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + sipq_pkg::idx_t'(1);
				if (place) begin
					placed_q <= 1'b1;
				end
				if (sts.last) begin
					if (op_q == sipq_pkg::OP_INSERT) begin
						count_q <= count_q + sipq_pkg::cnt_t'(1);
					end else begin
						count_q <= count_q - sipq_pkg::cnt_t'(1);
					end
				end
			end
		end
	end

	assign head_key    = res_key_q;
	assign head_tag    = res_tag_q;
	assign head_valid  = res_valid_q;
	assign entry_count = res_count_q;
	assign status      = res_status_q;

endmodule

@@ rtl/sorted_insert_priority_queue_core.sv @@
// Sorted insert priority queue core: up to 16 (key, tag) entries in slot memory.
// Insert walks the held entries to place the new one; remove shifts each towards slot 0;
// a refused operation skips the walk. Next transaction taken the cycle after the result
// registers. The walk runs over the slot memory's single read and write port.
// Reset clears the entry count and result valid and selects descending order;
// the slot memory is not cleared. Depends on sipq_pkg, sipq_ctrl, sipq_dp.
`include "sorted_insert_priority_queue_core_defines.svh"

module sorted_insert_priority_queue_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  sipq_pkg::key_t      entry_key,
	input  sipq_pkg::tag_t      entry_tag,
	output logic                out_valid,
	input  logic                out_stall,
	output sipq_pkg::key_t      head_key,
	output sipq_pkg::tag_t      head_tag,
	output logic                head_valid,
	output sipq_pkg::cnt_t      entry_count,
	output sipq_pkg::status_t   status
);

	sipq_pkg::cmd_t cmd;
	sipq_pkg::sts_t sts;

	// Sequence each transaction
	sipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Hold entries and build results
	sipq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.operation      (operation),
		.entry_key      (entry_key),
		.entry_tag      (entry_tag),
		.head_key       (head_key),
		.head_tag       (head_tag),
		.head_valid     (head_valid),
		.entry_count    (entry_count),
		.status         (status)
	);

	`SIPQ_ASSERT_SAME(a_count_bound, out_valid, entry_count <= sipq_pkg::cnt_t'(sipq_pkg::DEPTH), "entry count above depth")
	`SIPQ_ASSERT_SAME(a_head_valid, out_valid, head_valid == (entry_count != '0), "head valid disagrees with count")
	`SIPQ_ASSERT_SAME(a_full_count, out_valid && status == sipq_pkg::STATUS_FULL, entry_count == sipq_pkg::cnt_t'(sipq_pkg::DEPTH), "full status with room left")
	`SIPQ_ASSERT_SAME(a_empty_head, out_valid && status == sipq_pkg::STATUS_EMPTY, !head_valid && entry_count == '0, "empty status with entries held")
	`SIPQ_ASSERT_NEXT(a_busy_stall, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

@@ bench/sorted_insert_priority_queue_core_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sorted insert priority queue core: watches both channels and the
// configuration port, predicts each head report and compares it field by field.
// Depends on sipq_pkg for the key, tag, count, operation and status types.
module sorted_insert_priority_queue_core_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                operation,
	input  sipq_pkg::key_t      entry_key,
	input  sipq_pkg::tag_t      entry_tag,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sipq_pkg::key_t      head_key,
	input  sipq_pkg::tag_t      head_tag,
	input  logic                head_valid,
	input  sipq_pkg::cnt_t      entry_count,
	input  sipq_pkg::status_t   status,
	output int                  fail_count,
	output int                  pending_count,
	output int                  full_seen,
	output int                  empty_seen
);
	import sipq_pkg::*;

	typedef struct {
		key_t    key;
		tag_t    tag;
		logic    valid;
		cnt_t    count;
		status_t stat;
	} head_report_t;

	// Shadow copy of the queue contents and the ordering bit
	key_t         held_keys [DEPTH];
	tag_t         held_tags [DEPTH];
	int           held_fill = 0;
	logic         ascending = 1'b0;

	head_report_t head_reports_due [$];
	int           fails = 0;
	int           fulls = 0;
	int           empties = 0;

	assign fail_count    = fails;
	assign pending_count = head_reports_due.size();
	assign full_seen     = fulls;
	assign empty_seen    = empties;

	// True when the held key keeps its place ahead of the incoming key
	function automatic logic keeps_lead(input key_t held, input key_t incoming);
		return ascending ? (held < incoming) : (held > incoming);
	endfunction

	// Apply one transaction to the shadow queue and return the head report it causes
	task automatic apply_queue_op(input op_t op, input key_t key, input tag_t tag,
			output head_report_t rep);
		int pos;
		int i;
		rep.stat = STATUS_OK;
		if (op == OP_INSERT) begin
			if (held_fill >= DEPTH) begin
				rep.stat = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < held_fill && keeps_lead(held_keys[pos], key))
					pos++;
				for (i = held_fill; i > pos; i--) begin
					held_keys[i] = held_keys[i-1];
					held_tags[i] = held_tags[i-1];
				end
				held_keys[pos] = key;
				held_tags[pos] = tag;
				held_fill++;
			end
		end else begin
			if (held_fill == 0) begin
				rep.stat = STATUS_EMPTY;
			end else begin
				for (i = 0; i + 1 < held_fill; i++) begin
					held_keys[i] = held_keys[i+1];
					held_tags[i] = held_tags[i+1];
				end
				held_fill--;
			end
		end
		rep.valid = (held_fill > 0);
		rep.key   = rep.valid ? held_keys[0] : '0;
		rep.tag   = rep.valid ? held_tags[0] : '0;
		rep.count = cnt_t'(held_fill);
	endtask

	// Count a failure; report only the first few
	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (fails < 10)
			$display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		head_report_t want;
		head_report_t rep;
		if (!arst_n) begin
			held_fill = 0;
			ascending = 1'b0;
			head_reports_due.delete();
		end else begin
			// Compare an accepted result with the oldest expectation
			if (out_valid && !out_stall) begin
				if (head_reports_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: result transaction with nothing expected", $time);
					fails++;
				end else begin
					want = head_reports_due.pop_front();
					if (head_key !== want.key)
						note_mismatch("head_key", want.key, head_key);
					if (head_tag !== want.tag)
						note_mismatch("head_tag", want.tag, head_tag);
					if (head_valid !== want.valid)
						note_mismatch("head_valid", want.valid, head_valid);
					if (entry_count !== want.count)
						note_mismatch("entry_count", want.count, entry_count);
					if (status !== want.stat)
						note_mismatch("status", want.stat, status);
				end
			end
			// Track the ordering register
			if (cfg_write_en)
				ascending = cfg_write_data;
			// Predict the result of an accepted input transaction
			if (in_valid && !in_stall) begin
				apply_queue_op(op_t'(operation), entry_key, entry_tag, rep);
				if (rep.stat == STATUS_FULL)
					fulls++;
				if (rep.stat == STATUS_EMPTY)
					empties++;
				head_reports_due.push_back(rep);
			end
		end
	end

endmodule

@@ bench/sorted_insert_priority_queue_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted insert priority queue core: clock, reset, stimulus
// and verdict. Depends on sipq_pkg, the core and sorted_insert_priority_queue_core_checker.
module sorted_insert_priority_queue_core_tb;
	import sipq_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_write_en = 1'b0;
	logic    cfg_write_data = 1'b0;
	logic    in_valid = 1'b0;
	logic    operation = 1'b0;
	key_t    entry_key = '0;
	tag_t    entry_tag = '0;
	logic    out_stall = 1'b0;
	logic    in_stall;
	logic    out_valid;
	key_t    head_key;
	tag_t    head_tag;
	logic    head_valid;
	cnt_t    entry_count;
	status_t status;

	int      fails;
	int      pending;
	int      full_seen;
	int      empty_seen;

	// Idling controls, changed per phase
	bit      tail_quiet = 1'b0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      inserts_sent = 0;
	int      removes_sent = 0;
	int      order_writes = 0;

	always #10 clk = ~clk;

	sorted_insert_priority_queue_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.entry_key      (entry_key),
		.entry_tag      (entry_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.head_key       (head_key),
		.head_tag       (head_tag),
		.head_valid     (head_valid),
		.entry_count    (entry_count),
		.status         (status)
	);

	sorted_insert_priority_queue_core_checker head_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.entry_key      (entry_key),
		.entry_tag      (entry_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.head_key       (head_key),
		.head_tag       (head_tag),
		.head_valid     (head_valid),
		.entry_count    (entry_count),
		.status         (status),
		.fail_count     (fails),
		.pending_count  (pending),
		.full_seen      (full_seen),
		.empty_seen     (empty_seen)
	);

	// Mix extreme keys, a narrow range that forces ties, and full-width values
	function automatic key_t pick_key();
		int sel;
		sel = $urandom_range(0, 5);
		case (sel)
			0: return '0;
			1: return '1;
			2, 3: return key_t'($urandom_range(0, 7));
			default: return key_t'($urandom());
		endcase
	endfunction

	// Present one transaction, hold it until accepted, then maybe idle
	task automatic push_txn(input op_t op, input key_t key, input tag_t tag);
		in_valid  <= 1'b1;
		operation <= op;
		entry_key <= key;
		entry_tag <= tag;
		do @(posedge clk); while (in_stall);
		if (op == OP_INSERT)
			inserts_sent++;
		else
			removes_sent++;
		if (!tail_quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop valid, wait until every expected result has come, then let the bench idle
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (pending == 0);
		repeat (24) @(posedge clk);
	endtask

	// Write the ordering register while the core is idle
	task automatic write_order(input logic asc);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= asc;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		order_writes++;
		@(posedge clk);
	endtask

	// Stall the result channel in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!tail_quiet && arst_n && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int i;
		int ph;
		int n;
		int run_len;
		int ins_pct;
		int rates [3] = '{0, 8, 30};
		int biases [3] = '{90, 10, 50};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_order(1'b0);

		// Directed: refused remove, extremes, ties, fill to full and drop
		gap_pct   = 8;
		stall_pct = 8;
		push_txn(OP_REMOVE, '1, '1);
		push_txn(OP_INSERT, '0, '0);
		push_txn(OP_INSERT, '1, '1);
		push_txn(OP_INSERT, key_t'(5), tag_t'(8'h11));
		push_txn(OP_INSERT, key_t'(5), tag_t'(8'h22));
		for (i = 0; i < 12; i++)
			push_txn(OP_INSERT, pick_key(), tag_t'($urandom_range(0, 255)));
		push_txn(OP_INSERT, key_t'(32'h8000_0000), tag_t'(8'hA5));
		settle();

		// Flip to ascending while the queue is full, then shuffle entries
		write_order(1'b1);
		push_txn(OP_REMOVE, '0, '0);
		push_txn(OP_REMOVE, '1, '1);
		push_txn(OP_INSERT, key_t'(3), tag_t'(8'h33));
		push_txn(OP_INSERT, key_t'(3), tag_t'(8'h44));
		push_txn(OP_INSERT, '0, tag_t'(8'h55));
		settle();

		// Random phases: runs that fill, drain or hover, under varied idling
		for (ph = 0; ph < 8; ph++) begin
			write_order(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			gap_pct    = rates[$urandom_range(0, 2)];
			stall_pct  = rates[$urandom_range(0, 2)];
			tail_quiet = (ph == 7);
			n = 0;
			while (n < 181) begin
				run_len = $urandom_range(20, 40);
				// Trim the last run so each phase sends a fixed number of transactions
				if (run_len > 181 - n)
					run_len = 181 - n;
				ins_pct = biases[$urandom_range(0, 2)];
				for (i = 0; i < run_len; i++) begin
					if ($urandom_range(0, 99) < ins_pct)
						push_txn(OP_INSERT, pick_key(), tag_t'($urandom_range(0, 255)));
					else
						push_txn(OP_REMOVE, pick_key(), tag_t'($urandom_range(0, 255)));
				end
				n += run_len;
			end
			settle();
		end

		$display("Run covered %0d inserts and %0d removes across %0d ordering writes.",
			inserts_sent, removes_sent, order_writes);
		$display("Dropped inserts on a full queue: %0d; refused removes on an empty one: %0d.",
			full_seen, empty_seen);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
